// ===== rtl/pbfs_pkg.sv =====
// Shared types and constants for the packed bit-field store.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package pbfs_pkg;

  localparam int STORE_BYTES    = 256;
  localparam int MAX_FIELD_BITS = 64;

  localparam int WORD_BITS    = 64;
  localparam int STORE_WORDS  = (STORE_BYTES + 7) / 8;
  localparam int WORD_IDX_W   = $clog2(STORE_WORDS);
  localparam int BIT_SEL_W    = $clog2(WORD_BITS);

  localparam int OFFSET_W     = 12;
  localparam int WIDTH_W      = 7;
  localparam int USED_W       = 9;
  localparam int VBC_W        = 12;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_USED_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_BITS = 1'd1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_WIDTH  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd2;

  localparam logic [USED_W-1:0] USED_RESET = USED_W'(STORE_BYTES);
  localparam logic [VBC_W-1:0]  VBC_RESET  = VBC_W'(STORE_BYTES * 8);

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_in;   // capture request and its check result
    logic rd_en;     // read one store word
    logic rd_hi;     // 0: lower word of the window, 1: upper word
    logic cap_lo;    // capture lower word
    logic wr_lo;     // merge window, write lower word
    logic wr_hi;     // write upper word
    logic load_out;  // move result into output register
  } pbfs_cmd_t;

endpackage

// ===== rtl/packed_bit_field_store_top.sv =====
// Top level of the packed bit-field store: configuration registers, sequencer and datapath.
// Depends on pbfs_pkg, pbfs_ctrl and pbfs_dp.
//
//   channel  direction  handshake             payload
//   in_      request    in_valid / in_ready   opcode, field_offset, field_width, write_value
//   out_     result     out_valid / out_ready read_value, status
//   cfg_     config     cfg_we (no wait)      cfg_index, cfg_wdata
//
// A request steps through accept and check, lower-word read, upper-word read,
// merge and lower-word write, upper-word write and result hand-off. The word store
// reads or writes one word per cycle, and a field touches two words each way.
// Reset (synchronous, rst_n low) clears the sequencer, sets used_bytes to 256 and
// valid_bit_count to 2048, and marks every store word as zero at once.
// A stalled result holds in the output register; the next request is accepted
// meanwhile and waits in its last step until the output register frees up.
`timescale 1ns / 1ps

module packed_bit_field_store_top
  import pbfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [OFFSET_W-1:0]   in_field_offset,
  input  logic [WIDTH_W-1:0]    in_field_width,
  input  logic [WORD_BITS-1:0]  in_write_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [WORD_BITS-1:0]  out_read_value,
  output logic [STATUS_W-1:0]   out_status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers; the user must write them only while idle; the block does not enforce this
  logic [USED_W-1:0] used_bytes_r, used_bytes_nxt;
  logic [VBC_W-1:0]  vbc_r, vbc_nxt;

  always_comb begin
    used_bytes_nxt = used_bytes_r;
    vbc_nxt        = vbc_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_USED_BYTES: used_bytes_nxt = cfg_wdata[USED_W-1:0];
        CFG_VALID_BITS: vbc_nxt        = cfg_wdata[VBC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_bytes_r <= USED_RESET;
      vbc_r        <= VBC_RESET;
    end else begin
      used_bytes_r <= used_bytes_nxt;
      vbc_r        <= vbc_nxt;
    end
  end

  pbfs_cmd_t cmd;

  // step control and handshakes
  pbfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // check, store, extract and insert
  pbfs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .used_bytes      (used_bytes_r),
    .valid_bit_count (vbc_r),
    .in_opcode       (in_opcode),
    .in_field_offset (in_field_offset),
    .in_field_width  (in_field_width),
    .in_write_value  (in_write_value),
    .out_read_value  (out_read_value),
    .out_status      (out_status)
  );

endmodule

// ===== rtl/pbfs_ctrl.sv =====
// Sequencer for the packed bit-field store: input/output handshake and step control.
// Depends on pbfs_pkg.
`timescale 1ns / 1ps

module pbfs_ctrl
  import pbfs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pbfs_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_WR0   = 3'd3;
  localparam logic [2:0] S_WR1   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_hi  = 1'b1;
        cmd.cap_lo = 1'b1;
        state_nxt  = S_WR0;
      end
      S_WR0: begin
        cmd.wr_lo = 1'b1;
        state_nxt = S_WR1;
      end
      S_WR1: begin
        // repeating the upper write while stalled is harmless
        cmd.wr_hi = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/pbfs_dp.sv =====
// Datapath for the packed bit-field store: request check, word store, field extract/insert.
// Depends on pbfs_pkg; driven by pbfs_ctrl commands.
`timescale 1ns / 1ps

module pbfs_dp
  import pbfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  pbfs_cmd_t             cmd,
  input  logic [USED_W-1:0]     used_bytes,
  input  logic [VBC_W-1:0]      valid_bit_count,
  input  logic                  in_opcode,
  input  logic [OFFSET_W-1:0]   in_field_offset,
  input  logic [WIDTH_W-1:0]    in_field_width,
  input  logic [WORD_BITS-1:0]  in_write_value,
  output logic [WORD_BITS-1:0]  out_read_value,
  output logic [STATUS_W-1:0]   out_status
);

  function automatic logic [WORD_BITS-1:0] field_mask(input logic [WIDTH_W-1:0] w);
    logic [WORD_BITS-1:0] m;
    if (w >= WIDTH_W'(WORD_BITS)) m = '1;
    else m = (WORD_BITS'(1) << w) - WORD_BITS'(1);
    return m;
  endfunction

  // request check, evaluated on the input ports
  logic [USED_W-1:0]    sat_bytes;
  logic [VBC_W:0]       avail_bits;
  logic [OFFSET_W:0]    field_end;
  logic [WORD_BITS-1:0] in_mask;
  logic [STATUS_W-1:0]  chk_status;

  always_comb begin
    sat_bytes  = (used_bytes > USED_W'(STORE_BYTES)) ? USED_W'(STORE_BYTES) : used_bytes;
    avail_bits = {(VBC_W + 1 - USED_W - 3)'(0), sat_bytes, 3'b000};
    field_end  = {1'b0, in_field_offset} + (OFFSET_W + 1)'(in_field_width);
    in_mask    = field_mask(in_field_width);
    priority if (in_field_width > WIDTH_W'(MAX_FIELD_BITS))
      chk_status = ST_WIDTH;
    else if ({1'b0, valid_bit_count} > avail_bits)
      chk_status = ST_BOUNDS;
    else if (field_end > (OFFSET_W + 1)'(valid_bit_count))
      chk_status = ST_BOUNDS;
    else if (in_opcode == OP_WRITE && (in_write_value & ~in_mask) != '0)
      chk_status = ST_WIDTH;
    else
      chk_status = ST_OK;
  end

  // request registers
  logic [STATUS_W-1:0]   status_r;
  logic                  do_read_r, do_write_r;
  logic [WORD_IDX_W-1:0] w0_r, w1_r;
  logic [BIT_SEL_W-1:0]  shift_r;
  logic [WORD_BITS-1:0]  mask_r, value_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      status_r   <= chk_status;
      do_read_r  <= (chk_status == ST_OK) && (in_opcode == OP_READ);
      do_write_r <= (chk_status == ST_OK) && (in_opcode == OP_WRITE);
      w0_r       <= in_field_offset[BIT_SEL_W +: WORD_IDX_W];
      w1_r       <= in_field_offset[BIT_SEL_W +: WORD_IDX_W] + WORD_IDX_W'(1);
      shift_r    <= in_field_offset[BIT_SEL_W-1:0];
      mask_r     <= in_mask;
      value_r    <= in_write_value & in_mask;
    end
  end

  // word store; rows never written read as zero
  logic [WORD_BITS-1:0]   mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] row_valid_r;
  logic [WORD_BITS-1:0]   rdata_r;
  logic                   rvalid_r;
  logic                   we;
  logic [WORD_IDX_W-1:0]  waddr, raddr;
  logic [WORD_BITS-1:0]   wdata;
  logic [WORD_BITS-1:0]   rword;

  assign raddr = cmd.rd_hi ? w1_r : w0_r;
  assign rword = rvalid_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd_en) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rvalid_r    <= 1'b0;
    end else begin
      if (we) row_valid_r[waddr] <= 1'b1;
      if (cmd.rd_en) rvalid_r <= row_valid_r[raddr];
    end
  end

  // two-word window: extract and insert
  logic [WORD_BITS-1:0]   lo_r, new_hi_r, result_r;
  logic [2*WORD_BITS-1:0] window, win_mask, win_val, win_new, win_rd;

  always_comb begin
    window   = {rword, lo_r};
    win_mask = {{WORD_BITS{1'b0}}, mask_r} << shift_r;
    win_val  = {{WORD_BITS{1'b0}}, value_r} << shift_r;
    win_new  = (window & ~win_mask) | win_val;
    win_rd   = window >> shift_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) lo_r <= rword;
    if (cmd.wr_lo) begin
      new_hi_r <= win_new[2*WORD_BITS-1:WORD_BITS];
      result_r <= do_read_r ? (win_rd[WORD_BITS-1:0] & mask_r) : '0;
    end
  end

  always_comb begin
    we    = do_write_r && (cmd.wr_lo || cmd.wr_hi);
    waddr = cmd.wr_hi ? w1_r : w0_r;
    wdata = cmd.wr_hi ? new_hi_r : win_new[WORD_BITS-1:0];
  end

  // output register
  logic [WORD_BITS-1:0] out_value_r;
  logic [STATUS_W-1:0]  out_status_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r  <= result_r;
      out_status_r <= status_r;
    end
  end

  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

endmodule

// ===== bench/packed_bit_field_store_top_test.sv =====
// Self-checking bench for packed_bit_field_store_top: random and directed field requests,
// with a bit-level shadow store predicting every result. Depends on pbfs_pkg and the rtl/ tree.
`timescale 1ns / 1ps

module packed_bit_field_store_top_test;
  import pbfs_pkg::*;

  typedef struct packed {
    logic                 op;
    logic [OFFSET_W-1:0]  off;
    logic [WIDTH_W-1:0]   width;
    logic [WORD_BITS-1:0] value;
  } field_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [STATUS_W-1:0]  status;
  } field_result_t;

  // Clock, reset and every block input start at a known value.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_opcode = OP_READ;
  logic [OFFSET_W-1:0]   in_field_offset = '0;
  logic [WIDTH_W-1:0]    in_field_width = '0;
  logic [WORD_BITS-1:0]  in_write_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [WORD_BITS-1:0]  out_read_value;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_USED_BYTES;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the block: byte store plus both configuration registers.
  logic [7:0]       shadow_store [STORE_BYTES] = '{default: '0};
  logic [USED_W-1:0] shadow_used = USED_RESET;
  logic [VBC_W-1:0]  shadow_vbc = VBC_RESET;

  field_req_t    request_backlog[$];
  field_result_t expected_fields[$];
  field_req_t    req_live = '0;
  int            error_count = 0;
  int            cycle_count = 0;
  logic          calm;

  packed_bit_field_store_top u_top (.*);

  always #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // No idling on either side inside this stretch of the run.
  assign calm = (cycle_count >= 1500) && (cycle_count < 3500);

  // Apply one request to the shadow store and return the result it must produce.
  // Checks run in the block's order: width limit, valid bits against bytes in use
  // (bytes saturated at the store size), field against valid bits, then value width.
  function automatic field_result_t field_access(input field_req_t r);
    field_result_t res;
    int bytes_used;
    int vbc;
    int off;
    int wid;
    int pos;
    res.value  = '0;
    res.status = ST_OK;
    bytes_used = (shadow_used > STORE_BYTES) ? STORE_BYTES : int'(shadow_used);
    vbc = shadow_vbc;
    off = r.off;
    wid = r.width;
    if (wid > MAX_FIELD_BITS) begin
      res.status = ST_WIDTH;
    end else if (vbc > bytes_used * 8) begin
      res.status = ST_BOUNDS;
    end else if (off > vbc || wid > vbc - off) begin
      res.status = ST_BOUNDS;
    end else if (r.op == OP_READ) begin
      for (int i = 0; i < wid; i++) begin
        pos = off + i;
        if ((pos >> 3) < STORE_BYTES) res.value[i] = shadow_store[pos >> 3][pos & 7];
      end
    end else if (wid < WORD_BITS && (r.value >> wid) != '0) begin
      res.status = ST_WIDTH;
    end else begin
      for (int i = 0; i < wid; i++) begin
        pos = off + i;
        if ((pos >> 3) < STORE_BYTES) shadow_store[pos >> 3][pos & 7] = r.value[i];
      end
    end
    return res;
  endfunction

  // Random request shaped against the current shadow configuration: mostly
  // in-bounds fields with fitting values, then fields straddling the valid-bit
  // edge, then raw noise over every field bit.
  function automatic field_req_t make_request();
    field_req_t r;
    int vbc;
    int kind;
    int wid;
    int top;
    int span;
    logic [WORD_BITS-1:0] mask;
    vbc     = shadow_vbc;
    kind    = $urandom_range(0, 99);
    r.op    = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    r.value = {$urandom, $urandom};
    if (kind < 70) begin
      top = (vbc < MAX_FIELD_BITS) ? vbc : MAX_FIELD_BITS;
      case ($urandom_range(0, 4))
        0: wid = top;
        1: wid = (top > 0) ? top - 1 : 0;
        2: wid = $urandom_range(0, 1);
        default: wid = $urandom_range(0, top);
      endcase
      if (wid > top) wid = top;
      span = vbc - wid;
      // crowd half of the fields into the low bits so reads land on earlier writes
      if ($urandom_range(0, 1) && span > 320) span = 320;
      r.off   = OFFSET_W'($urandom_range(0, span));
      r.width = WIDTH_W'(wid);
      mask = (wid == WORD_BITS) ? '1 : (64'd1 << wid) - 64'd1;
      // leave one value in ten too wide for its field
      if (!(wid < WORD_BITS && $urandom_range(0, 9) == 0)) r.value &= mask;
    end else if (kind < 85) begin
      wid  = $urandom_range(0, MAX_FIELD_BITS + 2);
      span = vbc - wid + $urandom_range(0, 3) - 1;
      if (span < 0) span = 0;
      if (span > 4095) span = 4095;
      r.off   = OFFSET_W'(span);
      r.width = WIDTH_W'(wid);
      r.value = r.value >> $urandom_range(0, WORD_BITS - 1);
    end else begin
      r.off   = OFFSET_W'($urandom_range(0, 4095));
      r.width = WIDTH_W'($urandom_range(0, 127));
    end
    return r;
  endfunction

  task automatic add_request(input logic op, input int off, input int wid,
                             input logic [WORD_BITS-1:0] val);
    field_req_t r;
    r.op    = op;
    r.off   = OFFSET_W'(off);
    r.width = WIDTH_W'(wid);
    r.value = val;
    request_backlog.push_back(r);
  endtask

  // Drive one register write after the next rising edge and mirror it in the shadow copy.
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    if (idx == CFG_USED_BYTES) shadow_used = USED_W'(data);
    else shadow_vbc = VBC_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued request went in and every result came back.
  task automatic drain();
    while (request_backlog.size() != 0 || in_valid || expected_fields.size() != 0)
      @(negedge clk);
  endtask

  // Request driver: predict on acceptance, then present the next request or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_fields.push_back(field_access(req_live));
      if (!in_valid || in_ready) begin
        if (request_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
          req_live        <= request_backlog[0];
          in_opcode       <= request_backlog[0].op;
          in_field_offset <= request_backlog[0].off;
          in_field_width  <= request_backlog[0].width;
          in_write_value  <= request_backlog[0].value;
          in_valid        <= 1'b1;
          void'(request_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall at random, compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    field_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: result with nothing expected: read_value %h status %0d",
                   $time, out_read_value, out_status);
          error_count++;
        end else begin
          want = expected_fields.pop_front();
          if (out_read_value !== want.value) begin
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, want.value, out_read_value);
            error_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            error_count++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  // Configuration plan after the default phase: in-range limits, saturated
  // bytes in use, all-zero limits, valid bits past the store, valid bits past
  // the bytes in use, a small odd store, then back to the reset values.
  int used_plan [7] = '{200, 511, 0, 256, 100, 37, 256};
  int vbc_plan  [7] = '{1600, 2048, 0, 4095, 900, 296, 2048};
  int count_plan[7] = '{150, 150, 60, 60, 60, 150, 170};

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests under the reset configuration.
    add_request(OP_READ,  0,    0,   '0);                     // zero-width read
    add_request(OP_WRITE, 0,    64,  '1);                     // full-width write
    add_request(OP_READ,  0,    64,  '0);
    add_request(OP_WRITE, 3,    13,  64'h1ABC);
    add_request(OP_READ,  0,    20,  '0);
    add_request(OP_WRITE, 2040, 8,   64'hA5);                 // last byte
    add_request(OP_READ,  1984, 64,  '0);                     // field ends on the last bit
    add_request(OP_READ,  1985, 64,  '0);                     // one bit past the limit
    add_request(OP_READ,  2048, 0,   '0);                     // empty field at the limit
    add_request(OP_READ,  2049, 0,   '0);                     // empty field past the limit
    add_request(OP_READ,  0,    65,  '0);                     // width just over the max
    add_request(OP_WRITE, 4095, 127, '1);                     // width checked before bounds
    add_request(OP_WRITE, 100,  5,   64'h20);                 // value too wide: no change
    add_request(OP_READ,  100,  5,   '0);
    add_request(OP_WRITE, 61,   64,  64'hFEDC_BA98_7654_3211); // spans two store words
    add_request(OP_READ,  60,   64,  '0);
    add_request(OP_WRITE, 200,  63,  64'h8000_0000_0000_0000); // top bit outside the field
    add_request(OP_WRITE, 300,  0,   64'h1);                  // nonzero value, zero width
    add_request(OP_WRITE, 300,  0,   '0);
    add_request(OP_WRITE, 4095, 64,  '0);                     // offset far out of bounds
    add_request(OP_WRITE, 700,  64,  64'h0123_4567_89AB_CDEF);
    add_request(OP_READ,  700,  64,  '0);
    add_request(OP_READ,  703,  1,   '0);
    repeat (600) request_backlog.push_back(make_request());
    drain();

    for (int p = 0; p < 7; p++) begin
      set_register(CFG_USED_BYTES, used_plan[p]);
      set_register(CFG_VALID_BITS, vbc_plan[p]);
      @(negedge clk);
      repeat (count_plan[p]) request_backlog.push_back(make_request());
      drain();
    end

    // Keep the clock running before the final check so a stray extra result would still be caught.
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pbfs_pkg.sv
rtl/pbfs_ctrl.sv
rtl/pbfs_dp.sv
rtl/packed_bit_field_store_top.sv
bench/packed_bit_field_store_top_test.sv
